// ===== sv/tib_pkg.sv =====
// Package for the table interpolator: payload types, codes, state types and constants.
package tib_pkg;

   // Default table depth and the register's reset value.
   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam logic [10:0] TABLE_SIZE_RESET = 11'd2;

   // Widths of the serial multiply-divide unit.
   localparam int MD_W   = 33;
   localparam int PROD_W = 66;
   localparam int QUOT_W = 41;
   localparam logic [QUOT_W-1:0] QUOT_CAP = QUOT_W'(1) << 40;

   // Item modes.
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_INTERP = 2'd1;
   localparam logic [1:0] MODE_ROOT   = 2'd2;

   // Status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_ABOVE = 2'd1;
   localparam logic [1:0] STAT_BELOW = 2'd2;
   localparam logic [1:0] STAT_ZSTEP = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [9:0]         entry_index;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
      logic [30:0]        tolerance;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
   } rsp_type;

   // Request to and answer from the multiply-divide unit.
   typedef struct packed {
      logic            start;
      logic [MD_W-1:0] mcand;
      logic [MD_W-1:0] mplier;
      logic [MD_W-1:0] divisor;
   } md_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } md_rsp_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

   typedef enum logic [3:0] {
      TS_IDLE,
      TS_END,
      TS_ROOT,
      TS_EVAL,
      TS_JX,
      TS_RD_A,
      TS_RD_B,
      TS_MD,
      TS_POST,
      TS_RESP
   } tib_state_type;

endpackage

// ===== sv/tib_muldiv.sv =====
// Serial unit that returns floor(a*b/d), saturated at 2^40, one bit per cycle.
module tib_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  tib_pkg::md_req_type md_req,
   output tib_pkg::md_rsp_type md_rsp
);
   import tib_pkg::*;

   md_state_type      state_ff, state_in;
   logic [PROD_W-1:0] mcand_ff;
   logic [MD_W-1:0]   mplier_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [MD_W-1:0]   div_ff;
   logic [MD_W-1:0]   rem_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [6:0]        cnt_ff;
   logic              done_ff;

   logic [MD_W:0]     shifted;
   logic              take;
   logic [QUOT_W:0]   quot_next;

   // One restoring division step on the top bit of the product.
   always_comb begin
      shifted   = {rem_ff, prod_ff[PROD_W-1]};
      take      = shifted >= {1'b0, div_ff};
      quot_next = {quot_ff, take};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            if (cnt_ff == 7'(MD_W - 1)) begin
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            if (cnt_ff == 7'(PROD_W - 1)) begin
               state_in = MD_IDLE;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      md_rsp.done = done_ff;
      md_rsp.quot = quot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == MD_DIV) && (cnt_ff == 7'(PROD_W - 1));
      end
   end

   // Datapath: shift-add multiply, then shift-subtract divide.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         MD_IDLE: begin
            mcand_ff  <= PROD_W'(md_req.mcand);
            mplier_ff <= md_req.mplier;
            div_ff    <= md_req.divisor;
            prod_ff   <= '0;
            cnt_ff    <= '0;
         end
         MD_MUL: begin
            if (mplier_ff[0]) begin
               prod_ff <= prod_ff + mcand_ff;
            end
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
            if (cnt_ff == 7'(MD_W - 1)) begin
               cnt_ff  <= '0;
               rem_ff  <= '0;
               quot_ff <= '0;
            end else begin
               cnt_ff <= cnt_ff + 7'd1;
            end
         end
         MD_DIV: begin
            prod_ff <= prod_ff << 1;
            if (take) begin
               rem_ff <= MD_W'(shifted - {1'b0, div_ff});
            end else begin
               rem_ff <= shifted[MD_W-1:0];
            end
            if (quot_next > {1'b0, QUOT_CAP}) begin
               quot_ff <= QUOT_CAP;
            end else begin
               quot_ff <= quot_next[QUOT_W-1:0];
            end
            cnt_ff <= cnt_ff + 7'd1;
         end
         default: cnt_ff <= '0;
      endcase
   end

endmodule

// ===== sv/table_interp_bisection_root_core.sv =====
// Top level: uniform-grid table with linear interpolation and bisection root search.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   req_data (req_type)
//   rsp      out        rsp_valid/rsp_ready   rsp_data (rsp_type)
//   csr      in         csr_write_en          csr_write_data (table size)
//
// An interpolate item makes up to two passes through the serial multiply-divide
// unit (segment index, then slope term). A root item takes one such interpolation per
// bisection step, until the bounds lie within the tolerance.
// Reset is synchronous and clears control state; the table memories are not cleared.
// A waiting result does not stop the next item being accepted; the next result waits.
module table_interp_bisection_root_core #(
   parameter int TABLE_DEPTH = tib_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tib_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tib_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [10:0]      csr_write_data
);
   import tib_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Table memories.
   logic signed [31:0] x_mem [TABLE_DEPTH];
   logic signed [31:0] y_mem [TABLE_DEPTH];
   logic signed [31:0] x_rd_ff, y_rd_ff;

   tib_state_type      state_ff, state_in;
   logic [10:0]        size_ff;
   logic [1:0]         mode_ff;
   logic signed [31:0] xq_ff, yt_ff;
   logic [30:0]        tol_ff;
   logic signed [31:0] x0_ff, x1_ff, y0_ff, xl_ff, yl_ff;
   logic signed [31:0] lo_ff, hi_ff, xa_ff, ya_ff;
   logic [AW-1:0]      jx_ff;
   logic               neg_ff;
   logic signed [31:0] v_ff;
   logic [1:0]         s_ff, st_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            res_ff;

   logic               accept;
   logic [16:0]        ts_ext, n_used, last_idx, idx_ext;
   logic [AW-1:0]      last_addr, wr_addr, rd_addr;
   logic               idx_ok, mem_we, rd_en, rsp_free;
   logic signed [32:0] dx, xoff, dy, diff;
   logic [MD_W-1:0]    dx_mag, dy_mag, diff_mag;
   logic               above, below, zstep, dneg, jx_last;
   logic signed [33:0] lohi_sum, span;
   logic signed [31:0] mid;
   logic [30:0]        tol_eff;
   logic               more;
   logic signed [41:0] ya_ext, q_ext, interp_sum;
   logic signed [31:0] interp_sat;
   md_req_type         md_req;
   md_rsp_type         md_rsp;

   tib_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   // Table size in use, address decoding and handshake.
   always_comb begin
      accept   = req_valid && (state_ff == TS_IDLE);
      ts_ext   = 17'(size_ff);
      if (ts_ext < 17'd2) begin
         n_used = 17'd2;
      end else if (ts_ext > 17'(TABLE_DEPTH)) begin
         n_used = 17'(TABLE_DEPTH);
      end else begin
         n_used = ts_ext;
      end
      last_idx  = n_used - 17'd1;
      last_addr = last_idx[AW-1:0];
      idx_ext   = 17'(req_data.entry_index);
      idx_ok    = idx_ext < 17'(TABLE_DEPTH);
      wr_addr   = idx_ext[AW-1:0];
      rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // Interpolation arithmetic.
   always_comb begin
      dx       = 33'(x1_ff) - 33'(x0_ff);
      xoff     = 33'(xq_ff) - 33'(x0_ff);
      dy       = 33'(y_rd_ff) - 33'(ya_ff);
      diff     = 33'(xq_ff) - 33'(xa_ff);
      dx_mag   = dx[32] ? MD_W'(-dx) : MD_W'(dx);
      dy_mag   = dy[32] ? MD_W'(-dy) : MD_W'(dy);
      diff_mag = diff[32] ? MD_W'(-diff) : MD_W'(diff);
      above    = xq_ff > xl_ff;
      below    = xq_ff < x0_ff;
      zstep    = dx == 33'sd0;
      dneg     = dx[32];
      jx_last  = md_rsp.quot >= QUOT_W'(last_idx);
      ya_ext   = 42'(ya_ff);
      q_ext    = $signed({1'b0, md_rsp.quot});
      interp_sum = neg_ff ? (ya_ext - q_ext) : (ya_ext + q_ext);
      if (interp_sum > 42'sd2147483647) begin
         interp_sat = 32'sh7FFF_FFFF;
      end else if (interp_sum < -42'sd2147483648) begin
         interp_sat = 32'sh8000_0000;
      end else begin
         interp_sat = interp_sum[31:0];
      end
   end

   // Bisection bounds and stopping test.
   always_comb begin
      lohi_sum = 34'(lo_ff) + 34'(hi_ff);
      mid      = lohi_sum[32:1];
      span     = 34'(hi_ff) - 34'(lo_ff);
      tol_eff  = (tol_ff == '0) ? 31'd1 : tol_ff;
      more     = span > $signed({3'b000, tol_eff});
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TS_IDLE: begin
            if (accept) begin
               if (req_data.mode == MODE_INTERP || req_data.mode == MODE_ROOT) begin
                  state_in = TS_END;
               end else begin
                  state_in = TS_RESP;
               end
            end
         end
         TS_END: begin
            if (mode_ff == MODE_ROOT) begin
               state_in = TS_ROOT;
            end else begin
               state_in = TS_EVAL;
            end
         end
         TS_ROOT: state_in = more ? TS_EVAL : TS_RESP;
         TS_EVAL: begin
            if (above || below || zstep) begin
               state_in = TS_POST;
            end else if (dneg) begin
               state_in = TS_RD_A;
            end else begin
               state_in = TS_JX;
            end
         end
         TS_JX: begin
            if (md_rsp.done) begin
               state_in = jx_last ? TS_POST : TS_RD_A;
            end
         end
         TS_RD_A: state_in = TS_RD_B;
         TS_RD_B: state_in = TS_MD;
         TS_MD: begin
            if (md_rsp.done) begin
               state_in = TS_POST;
            end
         end
         TS_POST: state_in = (mode_ff == MODE_ROOT) ? TS_ROOT : TS_RESP;
         TS_RESP: begin
            if (rsp_free) begin
               state_in = TS_IDLE;
            end
         end
         default: state_in = TS_IDLE;
      endcase
   end

   // Memory and multiply-divide controls.
   always_comb begin
      mem_we         = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = last_addr;
      md_req.start   = 1'b0;
      md_req.mcand   = xoff[MD_W-1:0];
      md_req.mplier  = MD_W'(1);
      md_req.divisor = dx_mag;
      unique case (state_ff)
         TS_IDLE: begin
            mem_we = accept && (req_data.mode == MODE_LOAD) && idx_ok;
            rd_en  = accept;
         end
         TS_EVAL: begin
            rd_en        = !(above || below || zstep) && dneg;
            rd_addr      = '0;
            md_req.start = !(above || below || zstep || dneg);
         end
         TS_JX: begin
            rd_en   = md_rsp.done && !jx_last;
            rd_addr = md_rsp.quot[AW-1:0];
         end
         TS_RD_A: begin
            rd_en   = 1'b1;
            rd_addr = jx_ff + AW'(1);
         end
         TS_RD_B: begin
            md_req.start  = 1'b1;
            md_req.mcand  = dy_mag;
            md_req.mplier = diff_mag;
         end
         default: rd_en = 1'b0;
      endcase
   end

   // Table memories: one write port, one registered read port each.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         x_mem[wr_addr] <= req_data.x_value;
         y_mem[wr_addr] <= req_data.y_value;
      end
      if (rd_en) begin
         x_rd_ff <= x_mem[rd_addr];
         y_rd_ff <= y_mem[rd_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TS_IDLE;
         size_ff      <= TABLE_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            size_ff <= csr_write_data;
         end
         if (state_ff == TS_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == TS_RESP && rsp_free) begin
         rsp_ff <= res_ff;
      end
      unique case (state_ff)
         TS_IDLE: begin
            if (accept) begin
               mode_ff <= req_data.mode;
               xq_ff   <= req_data.x_value;
               yt_ff   <= req_data.y_value;
               tol_ff  <= req_data.tolerance;
               st_ff   <= STAT_OK;
               res_ff  <= '{result_value: 32'sd0, status: STAT_OK};
               // First two grid points are shadowed for the step and range tests.
               if (req_data.mode == MODE_LOAD && idx_ok) begin
                  if (req_data.entry_index == 10'd0) begin
                     x0_ff <= req_data.x_value;
                     y0_ff <= req_data.y_value;
                  end
                  if (req_data.entry_index == 10'd1) begin
                     x1_ff <= req_data.x_value;
                  end
               end
            end
         end
         TS_END: begin
            xl_ff <= x_rd_ff;
            yl_ff <= y_rd_ff;
            lo_ff <= x0_ff;
            hi_ff <= x_rd_ff;
         end
         TS_ROOT: begin
            xq_ff <= mid;
            if (!more) begin
               res_ff <= '{result_value: mid, status: st_ff};
            end
         end
         TS_EVAL: begin
            jx_ff <= '0;
            if (above) begin
               v_ff <= yl_ff;
               s_ff <= STAT_ABOVE;
            end else if (below) begin
               v_ff <= y0_ff;
               s_ff <= STAT_BELOW;
            end else if (zstep) begin
               v_ff <= y0_ff;
               s_ff <= STAT_ZSTEP;
            end else begin
               s_ff <= STAT_OK;
            end
         end
         TS_JX: begin
            jx_ff <= md_rsp.quot[AW-1:0];
            v_ff  <= yl_ff;
         end
         TS_RD_A: begin
            xa_ff <= x_rd_ff;
            ya_ff <= y_rd_ff;
         end
         TS_RD_B: begin
            neg_ff <= dy[32] ^ diff[32] ^ dx[32];
         end
         TS_MD: begin
            v_ff <= interp_sat;
         end
         TS_POST: begin
            if (mode_ff == MODE_ROOT) begin
               if (st_ff == STAT_OK) begin
                  st_ff <= s_ff;
               end
               if (v_ff > yt_ff) begin
                  hi_ff <= xq_ff;
               end else begin
                  lo_ff <= xq_ff;
               end
            end else begin
               res_ff <= '{result_value: v_ff, status: s_ff};
            end
         end
         default: begin
            neg_ff <= neg_ff;
         end
      endcase
   end

   assign req_ready = (state_ff == TS_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/interp_checker.sv =====
// Checker for the table interpolator: watches both channels, predicts each result and compares.
`timescale 1ns / 100ps

module interp_checker
   import tib_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [10:0] csr_write_data,
   output int          fail_count,
   output int          pending
);

   // Own copy of the table and of the size register.
   int           grid_x [DEFAULT_TABLE_DEPTH];
   int           grid_y [DEFAULT_TABLE_DEPTH];
   logic [10:0]  size_reg;
   rsp_type      awaited_q [$];

   initial begin
      foreach (grid_x[i]) begin
         grid_x[i] = 0;
         grid_y[i] = 0;
      end
   end

   function automatic int used_entries();
      int n;
      n = size_reg;
      if (n < 2) n = 2;
      if (n > DEFAULT_TABLE_DEPTH) n = DEFAULT_TABLE_DEPTH;
      return n;
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Slope term floor(a*b/d), held at the quotient cap.
   function automatic longint slope_term(input longint a, input longint b, input longint d);
      logic [127:0] prod;
      prod = 128'(a) * 128'(b);
      prod = prod / 128'(d);
      if (prod > 128'(QUOT_CAP)) prod = 128'(QUOT_CAP);
      return longint'(prod);
   endfunction

   // Linear interpolation at x, with clamping and the zero-step flag.
   function automatic void interpolate(input longint x, output longint val,
                                       output logic [1:0] st);
      int     n;
      longint x0, xl, dx, jx, ya, dy, diff, q, sum;
      logic   neg;
      n  = used_entries();
      x0 = grid_x[0];
      xl = grid_x[n-1];
      st = STAT_OK;
      if (x > xl) begin
         st  = STAT_ABOVE;
         val = grid_y[n-1];
         return;
      end
      if (x < x0) begin
         st  = STAT_BELOW;
         val = grid_y[0];
         return;
      end
      dx = longint'(grid_x[1]) - x0;
      if (dx == 0) begin
         st  = STAT_ZSTEP;
         val = grid_y[0];
         return;
      end
      jx = (x - x0) / dx;
      if (jx < 0) jx = 0;
      if (jx >= n - 1) begin
         val = grid_y[n-1];
         return;
      end
      ya   = grid_y[jx];
      dy   = longint'(grid_y[jx+1]) - ya;
      diff = x - grid_x[jx];
      neg  = ((dy < 0) != (diff < 0)) != (dx < 0);
      q    = slope_term(magnitude(dy), magnitude(diff), magnitude(dx));
      sum  = neg ? ya - q : ya + q;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      val = sum;
   endfunction

   // Expected result of one accepted item; loads also update the table.
   function automatic rsp_type predict_result(input req_type r);
      rsp_type    res;
      longint     lo, hi, mid, tol, v;
      logic [1:0] s;
      int         n;
      res.result_value = '0;
      res.status       = STAT_OK;
      case (r.mode)
         MODE_LOAD: begin
            grid_x[r.entry_index] = r.x_value;
            grid_y[r.entry_index] = r.y_value;
         end
         MODE_INTERP: begin
            interpolate(longint'(r.x_value), v, s);
            res.result_value = v[31:0];
            res.status       = s;
         end
         MODE_ROOT: begin
            n   = used_entries();
            lo  = grid_x[0];
            hi  = grid_x[n-1];
            mid = (lo + hi) >>> 1;
            tol = r.tolerance;
            if (tol < 1) tol = 1;
            while (hi - lo > tol) begin
               interpolate(mid, v, s);
               if (res.status == STAT_OK) res.status = s;
               if (v > longint'(r.y_value)) hi = mid;
               else lo = mid;
               mid = (lo + hi) >>> 1;
            end
            res.result_value = mid[31:0];
         end
         default: ;
      endcase
      return res;
   endfunction

   // Results are compared before new items are predicted in the same cycle.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         size_reg = TABLE_SIZE_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_q.size() == 0) begin
               $error("result item with nothing expected");
               fail_count++;
            end else begin
               want = awaited_q.pop_front();
               if (rsp_data.result_value !== want.result_value) begin
                  $error("result_value expected %0d actual %0d",
                         want.result_value, rsp_data.result_value);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_data.status);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) awaited_q.push_back(predict_result(req_data));
         if (csr_write_en) size_reg = csr_write_data;
      end
      pending = awaited_q.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the table interpolator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
   import tib_pkg::*;

   localparam int ITEM_GOAL   = 1750;
   localparam int STALL_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [10:0] csr_write_data = '0;
   int          fail_count;
   int          pending;

   int          sent_items = 0;
   int          sender_idle = 28;
   int          receiver_idle = 73;
   int          quiet_cycles = 0;
   int          table_x [DEFAULT_TABLE_DEPTH];
   int          table_y [DEFAULT_TABLE_DEPTH];
   int          entries_used = 2;

   table_interp_bisection_root_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   interp_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The receiver stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle);
      end
   end

   // Watchdog on cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("table_interp_bisection_root_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Hands one item to the block, with an occasional random gap first.
   task automatic send_item(input req_type r);
      if (sent_items == ITEM_GOAL / 3) begin
         sender_idle   = 73;
         receiver_idle = 28;
      end else if (sent_items == 2 * ITEM_GOAL / 3) begin
         sender_idle   = 0;
         receiver_idle = 0;
      end
      if ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // The size register is written only once the block has gone idle.
   task automatic write_size(input logic [10:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      entries_used = (value < 2) ? 2 : (value > DEFAULT_TABLE_DEPTH) ? DEFAULT_TABLE_DEPTH : value;
   endtask

   task automatic load_entry(input int idx, input int x, input int y);
      req_type r;
      r             = '0;
      r.mode        = MODE_LOAD;
      r.entry_index = idx[9:0];
      r.x_value     = x;
      r.y_value     = y;
      r.tolerance   = 31'($urandom);
      table_x[idx]  = x;
      table_y[idx]  = y;
      send_item(r);
   endtask

   task automatic send_query(input logic [1:0] mode, input int x, input int y,
                             input logic [30:0] tol);
      req_type r;
      r             = '0;
      r.mode        = mode;
      r.entry_index = 10'($urandom);
      r.x_value     = x;
      r.y_value     = y;
      r.tolerance   = tol;
      send_item(r);
   endtask

   // Loads entries 0..n-1 with a grid of the chosen shape and random content.
   task automatic load_grid(input int n);
      int     shape, step;
      longint x, y;
      shape = $urandom_range(99);
      x     = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      step  = $urandom_range(1, 32'h0010_0000);
      y     = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      for (int i = 0; i < n; i++) begin
         if (shape < 8) begin
            load_entry(i, int'($urandom), int'($urandom));
         end else begin
            load_entry(i, int'(x), (shape < 30) ? int'($urandom) : int'(y));
         end
         y = y + $urandom_range(0, 32'h0004_0000);
         if (shape >= 50 || shape < 30) x = x + step;
         else if (shape < 38) x = x - step;
         else if (shape < 44) x = (i == 0) ? x : x + step;
         else x = (i == 0) ? x - step : x + 2 * step;
      end
   endtask

   // One random query against the table that is loaded.
   task automatic random_query();
      longint      lo, hi, span, x, tol;
      logic [63:0] pick;
      int          kind;
      lo   = table_x[0];
      hi   = table_x[entries_used - 1];
      if (lo > hi) begin
         span = lo;
         lo   = hi;
         hi   = span;
      end
      span = hi - lo;
      pick = {$urandom, $urandom};
      x    = lo + longint'(pick % 64'(span + 1));
      kind = $urandom_range(99);
      if (kind < 10) x = int'($urandom);
      else if (kind < 20) x = (kind < 15) ? lo - $urandom_range(1, 64) : hi + $urandom_range(1, 64);
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
      tol = span >> $urandom_range(0, 8);
      kind = $urandom_range(99);
      if (kind < 6) tol = $urandom;
      else if (kind < 9) tol = 0;
      if (tol > 64'sd2147483647) tol = 64'sd2147483647;
      kind = $urandom_range(99);
      if (kind < 3) begin
         send_query(2'd3, int'($urandom), int'($urandom), 31'($urandom));
      end else if (kind < 38) begin
         send_query(MODE_ROOT, int'($urandom),
                    (kind < 10) ? int'($urandom) : table_y[$urandom_range(0, entries_used - 1)],
                    31'(tol));
      end else begin
         send_query(MODE_INTERP, int'(x), int'($urandom), 31'($urandom));
      end
   endtask

   task automatic query_burst(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(19) == 0) wait_drained();
         random_query();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items on the two-entry table left by reset.
      load_entry(0, 0, 0);
      load_entry(1, 32'sh0001_0000, 32'sh7fff_ffff);
      send_query(MODE_INTERP, 32'sh0000_8000, 0, 31'd1);
      send_query(MODE_INTERP, -1, 0, 31'd1);
      send_query(MODE_INTERP, 32'sh0001_0001, 0, 31'd1);
      send_query(MODE_INTERP, 32'sh0001_0000, 0, 31'd1);
      send_query(MODE_INTERP, 32'sh8000_0000, 0, 31'd1);
      send_query(MODE_INTERP, 32'sh7fff_ffff, 0, 31'd1);
      send_query(MODE_ROOT, 0, 32'sh4000_0000, 31'd0);
      send_query(MODE_ROOT, 0, 32'sh8000_0000, 31'h7fff_ffff);
      send_query(2'd3, 32'sh7fff_ffff, -1, 31'h7fff_ffff);
      // Zero grid step inside the range.
      load_entry(1, 0, 32'sh8000_0000);
      send_query(MODE_INTERP, 0, 0, 31'd1);
      send_query(MODE_ROOT, 0, 0, 31'd1);
      // Reversed span: the last x lies below the first.
      load_entry(0, 32'sh0001_0000, -5);
      load_entry(1, 0, 7);
      send_query(MODE_ROOT, 0, 0, 31'd1);
      send_query(MODE_INTERP, 32'sh0000_8000, 0, 31'd1);
      load_entry(1023, 32'sh8000_0000, 32'sh7fff_ffff);

      // Largest size: an oversize write saturates to the full depth.
      write_size(11'h7ff);
      load_grid(DEFAULT_TABLE_DEPTH);
      query_burst(60);
      write_size(11'd1024);
      query_burst(30);

      // Many small tables, with the smallest settings among them.
      while (sent_items < ITEM_GOAL) begin
         case ($urandom_range(7))
            0:       write_size(11'd0);
            1:       write_size(11'd1);
            default: write_size(11'($urandom_range(2, 48)));
         endcase
         load_grid(entries_used);
         query_burst(30);
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("table_interp_bisection_root_core: match");
      end else begin
         $display("table_interp_bisection_root_core: mismatch");
      end
      $finish;
   end

endmodule
